### src/otcr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// otcr_pkg
// Shared types, constants and the 5x7 font table of the OLED text renderer.
// ----------------------------------------------------------------------------
package otcr_pkg;

  localparam int DISPLAY_COLUMNS_DEF = 128;
  localparam int DISPLAY_PAGES_DEF   = 8;
  localparam int QUEUE_DEPTH         = 2;
  localparam int GLYPH_PITCH         = 6;

  localparam logic [7:0] FIRST_GLYPH       = 8'd32;
  localparam logic [7:0] LAST_GLYPH        = 8'd126;
  localparam logic [7:0] NUL_CODE          = 8'h00;
  localparam logic [7:0] CTRL_COMMAND      = 8'h00;
  localparam logic [7:0] CTRL_DATA         = 8'h40;
  localparam logic [7:0] CMD_COLUMN_WINDOW = 8'h21;
  localparam logic [7:0] CMD_PAGE_WINDOW   = 8'h22;
  localparam logic [7:0] SPACER_COLUMN     = 8'h00;

  // byte positions within the 20-byte write sequence of one glyph
  localparam logic [4:0] STEP_COL_CMD     = 5'd1;
  localparam logic [4:0] STEP_COL_START   = 5'd3;
  localparam logic [4:0] STEP_COL_END     = 5'd5;
  localparam logic [4:0] STEP_PAGE_CMD    = 5'd7;
  localparam logic [4:0] STEP_PAGE_START  = 5'd9;
  localparam logic [4:0] STEP_PAGE_END    = 5'd11;
  localparam logic [4:0] STEP_DATA_CTRL   = 5'd12;
  localparam logic [4:0] STEP_GLYPH0      = 5'd13;
  localparam logic [4:0] STEP_GLYPH1      = 5'd14;
  localparam logic [4:0] STEP_GLYPH2      = 5'd15;
  localparam logic [4:0] STEP_GLYPH3      = 5'd16;
  localparam logic [4:0] STEP_GLYPH4      = 5'd17;
  localparam logic [4:0] STEP_SPACER_CTRL = 5'd18;
  localparam logic [4:0] STEP_LAST        = 5'd19;

  typedef struct packed {
    logic [6:0] glyph;
    logic [7:0] col_byte;
    logic [7:0] page_byte;
  } otcr_job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } otcr_q_status_t;

  // column 0 of each glyph in the top byte
  localparam logic [39:0] GLYPH_ROM [95] = '{
    40'h0000000000, 40'h00002f0000, 40'h0007000700, 40'h147f147f14,
    40'h242a7f2a12, 40'h2313086462, 40'h3649552250, 40'h0005030000,
    40'h001c224100, 40'h0041221c00, 40'h14083e0814, 40'h08083e0808,
    40'h0000a06000, 40'h0808080808, 40'h0060600000, 40'h2010080402,
    40'h3e5149453e, 40'h00427f4000, 40'h4261514946, 40'h2141454b31,
    40'h1814127f10, 40'h2745454539, 40'h3c4a494930, 40'h0171090503,
    40'h3649494936, 40'h064949291e, 40'h0036360000, 40'h0056360000,
    40'h0814224100, 40'h1414141414, 40'h0041221408, 40'h0201510906,
    40'h324959513e, 40'h7c1211127c, 40'h7f49494936, 40'h3e41414122,
    40'h7f4141221c, 40'h7f49494941, 40'h7f09090901, 40'h3e4149497a,
    40'h7f0808087f, 40'h00417f4100, 40'h2040413f01, 40'h7f08142241,
    40'h7f40404040, 40'h7f020c027f, 40'h7f0408107f, 40'h3e4141413e,
    40'h7f09090906, 40'h3e4151215e, 40'h7f09192946, 40'h4649494931,
    40'h01017f0101, 40'h3f4040403f, 40'h1f2040201f, 40'h3f4038403f,
    40'h6314081463, 40'h0708700807, 40'h6151494543, 40'h007f414100,
    40'h55aa55aa55, 40'h0041417f00, 40'h0402010204, 40'h4040404040,
    40'h0003050000, 40'h2054545478, 40'h7f48444438, 40'h3844444420,
    40'h384444487f, 40'h3854545418, 40'h087e090102, 40'h18a4a4a47c,
    40'h7f08040478, 40'h00447d4000, 40'h4080847d00, 40'h7f10284400,
    40'h00417f4000, 40'h7c04180478, 40'h7c08040478, 40'h3844444438,
    40'hfc24242418, 40'h18242418fc, 40'h7c08040408, 40'h4854545420,
    40'h043f444020, 40'h3c4040207c, 40'h1c2040201c, 40'h3c4030403c,
    40'h4428102844, 40'h1ca0a0a07c, 40'h4464544c44, 40'h00107c8200,
    40'h0000ff0000, 40'h00827c1000, 40'h0006090906
  };

endpackage

### src/otcr_ifs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// otcr_ifs
// Valid/ready channel interfaces for characters in and write bytes out.
// ----------------------------------------------------------------------------
interface otcr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       start_of_text;

  modport source (output valid, output char_code, output start_of_text, input ready);
  modport sink   (input valid, input char_code, input start_of_text, output ready);
endinterface

interface otcr_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       transfer_start;
  logic       last;

  modport source (output valid, output out_byte, output transfer_start, output last,
                  input ready);
  modport sink   (input valid, input out_byte, input transfer_start, input last,
                  output ready);
endinterface

### src/otcr_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// otcr_front
// Accepts characters, keeps the text cursor and queues a draw job for each
// printable character.
// ----------------------------------------------------------------------------
module otcr_front #(
  parameter int DISPLAY_COLUMNS = otcr_pkg::DISPLAY_COLUMNS_DEF,
  parameter int DISPLAY_PAGES   = otcr_pkg::DISPLAY_PAGES_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  otcr_in_if.sink                in_ch,
  input  otcr_pkg::otcr_q_status_t q_status,
  output logic                   push_valid,
  output otcr_pkg::otcr_job_t    push_job
);

  localparam int CW = $clog2(DISPLAY_COLUMNS + 1);
  localparam int PW = $clog2(DISPLAY_PAGES + 1);

  logic [CW-1:0] col_r, col_nxt, col_v, col_w;
  logic [PW-1:0] page_r, page_nxt, page_v, page_w;
  logic          stopped_r, stopped_nxt, stop_v;
  logic [CW:0]   col_sum, col_adv;
  logic [PW:0]   page_inc;
  logic          accept, wrap, past_end, printable;

  assign in_ch.ready = !q_status.full;
  assign accept      = in_ch.valid && !q_status.full;

  always_comb begin
    col_v     = in_ch.start_of_text ? '0 : col_r;
    page_v    = in_ch.start_of_text ? '0 : page_r;
    stop_v    = in_ch.start_of_text ? 1'b0 : stopped_r;
    col_sum   = {1'b0, col_v} + (CW+1)'(otcr_pkg::GLYPH_PITCH);
    wrap      = col_sum > (CW+1)'(DISPLAY_COLUMNS);
    page_inc  = {1'b0, page_v} + (PW+1)'(1);
    past_end  = page_inc >= (PW+1)'(DISPLAY_PAGES);
    printable = (in_ch.char_code >= otcr_pkg::FIRST_GLYPH) &&
                (in_ch.char_code <= otcr_pkg::LAST_GLYPH);
    col_w     = wrap ? '0 : col_v;
    page_w    = wrap ? PW'(page_inc) : page_v;
    col_adv   = {1'b0, col_w} + (CW+1)'(otcr_pkg::GLYPH_PITCH);

    col_nxt     = col_r;
    page_nxt    = page_r;
    stopped_nxt = stopped_r;
    push_valid  = 1'b0;

    if (accept) begin
      col_nxt     = col_v;
      page_nxt    = page_v;
      stopped_nxt = stop_v;
      if (!stop_v) begin
        if (in_ch.char_code == otcr_pkg::NUL_CODE) begin
          stopped_nxt = 1'b1;
        end else if (wrap && past_end) begin
          stopped_nxt = 1'b1;
          col_nxt     = '0;
          page_nxt    = PW'(page_inc);
        end else begin
          push_valid = printable;
          col_nxt    = CW'(col_adv);
          page_nxt   = page_w;
        end
      end
    end

    push_job.glyph     = 7'(in_ch.char_code - otcr_pkg::FIRST_GLYPH);
    push_job.col_byte  = 8'(col_w);
    push_job.page_byte = 8'(page_w);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r     <= '0;
      page_r    <= '0;
      stopped_r <= 1'b0;
    end else begin
      col_r     <= col_nxt;
      page_r    <= page_nxt;
      stopped_r <= stopped_nxt;
    end
  end

endmodule

### src/otcr_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// otcr_queue
// Short first-in first-out queue of draw jobs between front and back.
// ----------------------------------------------------------------------------
module otcr_queue (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     push_valid,
  input  otcr_pkg::otcr_job_t      push_job,
  input  logic                     pop,
  output otcr_pkg::otcr_job_t      pop_job,
  output otcr_pkg::otcr_q_status_t q_status
);

  localparam int AW = $clog2(otcr_pkg::QUEUE_DEPTH);
  localparam int NW = $clog2(otcr_pkg::QUEUE_DEPTH + 1);

  otcr_pkg::otcr_job_t entry_r [otcr_pkg::QUEUE_DEPTH];
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [NW-1:0] count_r, count_nxt;
  logic          do_push, do_pop;

  assign q_status.full  = count_r == NW'(otcr_pkg::QUEUE_DEPTH);
  assign q_status.empty = count_r == '0;
  assign do_push        = push_valid && !q_status.full;
  assign do_pop         = pop && !q_status.empty;
  assign pop_job        = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(otcr_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + AW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(otcr_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + AW'(1);
    end
    count_nxt = count_r + NW'(do_push) - NW'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

### src/otcr_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// otcr_back
// Sequences the 20 write bytes of each queued glyph into a registered
// output stage.
// ----------------------------------------------------------------------------
module otcr_back #(
  parameter int DISPLAY_COLUMNS = otcr_pkg::DISPLAY_COLUMNS_DEF,
  parameter int DISPLAY_PAGES   = otcr_pkg::DISPLAY_PAGES_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  otcr_pkg::otcr_q_status_t q_status,
  input  otcr_pkg::otcr_job_t      pop_job,
  output logic                     pop,
  otcr_out_if.source               out_ch
);

  localparam logic [7:0] COL_END_BYTE  = 8'(DISPLAY_COLUMNS - 1);
  localparam logic [7:0] PAGE_END_BYTE = 8'(DISPLAY_PAGES - 1);

  otcr_pkg::otcr_job_t job_r, job_nxt;
  logic [4:0]  step_r, step_nxt;
  logic        busy_r, busy_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [7:0]  out_byte_r, out_byte_nxt;
  logic        ts_r, ts_nxt, last_r, last_nxt;
  logic [39:0] glyph;
  logic        can_load, emit, at_last;
  logic [7:0]  gen_byte;
  logic        gen_ts, gen_last;

  assign out_ch.valid          = out_valid_r;
  assign out_ch.out_byte       = out_byte_r;
  assign out_ch.transfer_start = ts_r;
  assign out_ch.last           = last_r;

  assign glyph    = otcr_pkg::GLYPH_ROM[job_r.glyph];
  assign can_load = !out_valid_r || out_ch.ready;
  assign emit     = busy_r && can_load;
  assign at_last  = step_r == otcr_pkg::STEP_LAST;
  assign pop      = !q_status.empty && (!busy_r || (emit && at_last));

  always_comb begin
    gen_ts   = 1'b0;
    gen_last = 1'b0;
    case (step_r)
      otcr_pkg::STEP_COL_CMD:     gen_byte = otcr_pkg::CMD_COLUMN_WINDOW;
      otcr_pkg::STEP_COL_START:   gen_byte = job_r.col_byte;
      otcr_pkg::STEP_COL_END:     gen_byte = COL_END_BYTE;
      otcr_pkg::STEP_PAGE_CMD:    gen_byte = otcr_pkg::CMD_PAGE_WINDOW;
      otcr_pkg::STEP_PAGE_START:  gen_byte = job_r.page_byte;
      otcr_pkg::STEP_PAGE_END:    gen_byte = PAGE_END_BYTE;
      otcr_pkg::STEP_DATA_CTRL: begin
        gen_byte = otcr_pkg::CTRL_DATA;
        gen_ts   = 1'b1;
      end
      otcr_pkg::STEP_GLYPH0:      gen_byte = glyph[39:32];
      otcr_pkg::STEP_GLYPH1:      gen_byte = glyph[31:24];
      otcr_pkg::STEP_GLYPH2:      gen_byte = glyph[23:16];
      otcr_pkg::STEP_GLYPH3:      gen_byte = glyph[15:8];
      otcr_pkg::STEP_GLYPH4:      gen_byte = glyph[7:0];
      otcr_pkg::STEP_SPACER_CTRL: begin
        gen_byte = otcr_pkg::CTRL_DATA;
        gen_ts   = 1'b1;
      end
      otcr_pkg::STEP_LAST: begin
        gen_byte = otcr_pkg::SPACER_COLUMN;
        gen_last = 1'b1;
      end
      default: begin
        // control byte opening each command write
        gen_byte = otcr_pkg::CTRL_COMMAND;
        gen_ts   = 1'b1;
      end
    endcase
  end

  always_comb begin
    job_nxt       = job_r;
    step_nxt      = step_r;
    busy_nxt      = busy_r;
    out_valid_nxt = out_valid_r;
    out_byte_nxt  = out_byte_r;
    ts_nxt        = ts_r;
    last_nxt      = last_r;

    if (can_load) begin
      out_valid_nxt = busy_r;
      out_byte_nxt  = gen_byte;
      ts_nxt        = gen_ts;
      last_nxt      = gen_last;
    end

    if (pop) begin
      job_nxt  = pop_job;
      step_nxt = '0;
      busy_nxt = 1'b1;
    end else if (emit) begin
      step_nxt = step_r + 5'd1;
      if (at_last) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    job_r      <= job_nxt;
    out_byte_r <= out_byte_nxt;
    ts_r       <= ts_nxt;
    last_r     <= last_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r      <= '0;
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      step_r      <= step_nxt;
      busy_r      <= busy_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

### src/oled_text_cursor_renderer_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oled_text_cursor_renderer_top
// Character stream to I2C write bytes for a page-addressed OLED, 5x7 font.
// ----------------------------------------------------------------------------
// Each printable character (32..126) becomes 20 output bytes: six command
// writes setting the column and page window, a data write of five font
// columns and a data write of one blank column; transfer_start flags every
// control byte and last flags the final byte. The output side sends one
// byte per cycle while the sink is ready, paced by the byte sequencer in
// the back end. Characters are taken in one per cycle while the two-entry
// job queue has room; skipped codes, NUL and input while stopped produce
// no bytes. A character's job passes the job queue and the back end's job
// register before its first byte reaches the output register.
// ----------------------------------------------------------------------------
module oled_text_cursor_renderer_top #(
  parameter int DISPLAY_COLUMNS = otcr_pkg::DISPLAY_COLUMNS_DEF,
  parameter int DISPLAY_PAGES   = otcr_pkg::DISPLAY_PAGES_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  otcr_in_if.sink    in_ch,
  otcr_out_if.source out_ch
);

  otcr_pkg::otcr_job_t      push_job, pop_job;
  otcr_pkg::otcr_q_status_t q_status;
  logic                     push_valid, pop;

  otcr_front #(
    .DISPLAY_COLUMNS (DISPLAY_COLUMNS),
    .DISPLAY_PAGES   (DISPLAY_PAGES)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .q_status   (q_status),
    .push_valid (push_valid),
    .push_job   (push_job)
  );

  otcr_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_job   (push_job),
    .pop        (pop),
    .pop_job    (pop_job),
    .q_status   (q_status)
  );

  otcr_back #(
    .DISPLAY_COLUMNS (DISPLAY_COLUMNS),
    .DISPLAY_PAGES   (DISPLAY_PAGES)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_status (q_status),
    .pop_job  (pop_job),
    .pop      (pop),
    .out_ch   (out_ch)
  );

endmodule

### sim/oled_text_cursor_renderer_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oled_text_cursor_renderer_top_tb
// Self-checking bench for the OLED text renderer: characters in, I2C bytes out.
// ----------------------------------------------------------------------------
// A queue of characters feeds a clocked driver with random gaps. A clocked
// monitor takes output bytes under random backpressure. Each accepted
// character runs through a cursor/font model kept in the bench, and the
// resulting write bytes are queued. Every byte the block sends is compared
// field by field with the oldest queued byte. Stimulus covers printable and
// skipped codes, NUL, the start flag, line wrap and running off the last page.
// ----------------------------------------------------------------------------
module oled_text_cursor_renderer_top_tb;

  localparam int COLS        = 128;
  localparam int PAGES       = 8;
  localparam int PITCH       = 6;
  localparam int CYCLE_LIMIT = 600000;

  localparam logic [7:0] NUL         = 8'h00;
  localparam logic [7:0] FIRST_PRINT = 8'd32;
  localparam logic [7:0] LAST_PRINT  = 8'd126;
  localparam logic [7:0] CTL_CMD     = 8'h00;
  localparam logic [7:0] CTL_DATA    = 8'h40;
  localparam logic [7:0] CMD_COLWIN  = 8'h21;
  localparam logic [7:0] CMD_PAGEWIN = 8'h22;
  localparam logic [7:0] BLANK_COL   = 8'h00;

  // column 0 of each glyph in the top byte
  localparam logic [39:0] FONT_5X7 [95] = '{
    40'h0000000000, 40'h00002f0000, 40'h0007000700, 40'h147f147f14,
    40'h242a7f2a12, 40'h2313086462, 40'h3649552250, 40'h0005030000,
    40'h001c224100, 40'h0041221c00, 40'h14083e0814, 40'h08083e0808,
    40'h0000a06000, 40'h0808080808, 40'h0060600000, 40'h2010080402,
    40'h3e5149453e, 40'h00427f4000, 40'h4261514946, 40'h2141454b31,
    40'h1814127f10, 40'h2745454539, 40'h3c4a494930, 40'h0171090503,
    40'h3649494936, 40'h064949291e, 40'h0036360000, 40'h0056360000,
    40'h0814224100, 40'h1414141414, 40'h0041221408, 40'h0201510906,
    40'h324959513e, 40'h7c1211127c, 40'h7f49494936, 40'h3e41414122,
    40'h7f4141221c, 40'h7f49494941, 40'h7f09090901, 40'h3e4149497a,
    40'h7f0808087f, 40'h00417f4100, 40'h2040413f01, 40'h7f08142241,
    40'h7f40404040, 40'h7f020c027f, 40'h7f0408107f, 40'h3e4141413e,
    40'h7f09090906, 40'h3e4151215e, 40'h7f09192946, 40'h4649494931,
    40'h01017f0101, 40'h3f4040403f, 40'h1f2040201f, 40'h3f4038403f,
    40'h6314081463, 40'h0708700807, 40'h6151494543, 40'h007f414100,
    40'h55aa55aa55, 40'h0041417f00, 40'h0402010204, 40'h4040404040,
    40'h0003050000, 40'h2054545478, 40'h7f48444438, 40'h3844444420,
    40'h384444487f, 40'h3854545418, 40'h087e090102, 40'h18a4a4a47c,
    40'h7f08040478, 40'h00447d4000, 40'h4080847d00, 40'h7f10284400,
    40'h00417f4000, 40'h7c04180478, 40'h7c08040478, 40'h3844444438,
    40'hfc24242418, 40'h18242418fc, 40'h7c08040408, 40'h4854545420,
    40'h043f444020, 40'h3c4040207c, 40'h1c2040201c, 40'h3c4030403c,
    40'h4428102844, 40'h1ca0a0a07c, 40'h4464544c44, 40'h00107c8200,
    40'h0000ff0000, 40'h00827c1000, 40'h0006090906
  };

  typedef struct packed {
    logic [7:0] code;
    logic       sot;
  } char_item_t;

  typedef struct packed {
    logic [7:0] value;
    logic       opens;
    logic       fin;
  } wr_byte_t;

  logic clk;
  logic rst_n;

  otcr_in_if  in_ch ();
  otcr_out_if out_ch ();

  oled_text_cursor_renderer_top #(
    .DISPLAY_COLUMNS (COLS),
    .DISPLAY_PAGES   (PAGES)
  ) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  char_item_t char_fifo [$];
  wr_byte_t   bytes_due [$];

  // text cursor of the bench's own model
  logic [8:0] col_pos;
  logic [4:0] page_pos;
  logic       halted;

  int errors;
  int cycles;
  int glyphs_drawn;
  int line_wraps;
  int nul_stops;
  int screen_full_stops;
  int bytes_checked;

  logic in_fired;
  logic out_fired;
  int   in_gap;
  int   out_stall;
  logic in_burst;
  logic out_burst;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic void push_byte(logic [7:0] value, logic opens, logic fin);
    wr_byte_t b;
    b.value = value;
    b.opens = opens;
    b.fin   = fin;
    bytes_due.push_back(b);
  endfunction

  function automatic void push_cmd(logic [7:0] cmd);
    push_byte(CTL_CMD, 1'b1, 1'b0);
    push_byte(cmd, 1'b0, 1'b0);
  endfunction

  function automatic void render_char(logic [7:0] code, logic sot);
    logic [39:0] glyph;
    if (sot) begin
      col_pos  = '0;
      page_pos = '0;
      halted   = 1'b0;
    end
    if (halted) return;
    if (code == NUL) begin
      halted = 1'b1;
      nul_stops++;
      return;
    end
    if (int'(col_pos) + PITCH > COLS) begin
      col_pos  = '0;
      page_pos = page_pos + 5'd1;
      line_wraps++;
      if (int'(page_pos) >= PAGES) begin
        halted = 1'b1;
        screen_full_stops++;
        return;
      end
    end
    if (code >= FIRST_PRINT && code <= LAST_PRINT) begin
      glyph = FONT_5X7[code - FIRST_PRINT];
      push_cmd(CMD_COLWIN);
      push_cmd(col_pos[7:0]);
      push_cmd(8'(COLS - 1));
      push_cmd(CMD_PAGEWIN);
      push_cmd(8'(page_pos));
      push_cmd(8'(PAGES - 1));
      push_byte(CTL_DATA, 1'b1, 1'b0);
      for (int i = 0; i < 5; i++)
        push_byte(glyph[39 - 8 * i -: 8], 1'b0, 1'b0);
      push_byte(CTL_DATA, 1'b1, 1'b0);
      push_byte(BLANK_COL, 1'b0, 1'b1);
      glyphs_drawn++;
    end
    col_pos = col_pos + 9'(PITCH);
  endfunction

  function automatic void add_char(logic [7:0] code, logic sot);
    char_item_t c;
    c.code = code;
    c.sot  = sot;
    char_fifo.push_back(c);
  endfunction

  function automatic logic [7:0] any_printable();
    return 8'($urandom_range(32, 126));
  endfunction

  function automatic logic [7:0] any_skipped();
    return ($urandom_range(0, 1) == 0) ? 8'($urandom_range(1, 31))
                                       : 8'($urandom_range(127, 255));
  endfunction

  // fills every slot of the screen with mostly skipped codes, then overruns it
  function automatic void fill_screen();
    logic [7:0] code;
    for (int i = 0; i < 172; i++) begin
      code = (i % 21 == 0 || i % 21 == 20 || i >= 165) ? any_printable() : any_skipped();
      add_char(code, i == 0);
    end
  endfunction

  // sampling at the rising edge: prediction and comparison
  always @(posedge clk) begin
    wr_byte_t exp_b;
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      in_fired  <= rst_n && in_ch.valid && in_ch.ready;
      out_fired <= rst_n && out_ch.valid && out_ch.ready;
      if (rst_n && in_ch.valid && in_ch.ready)
        render_char(in_ch.char_code, in_ch.start_of_text);
      if (rst_n && out_ch.valid && out_ch.ready) begin
        bytes_checked++;
        if (bytes_due.size() == 0) begin
          errors++;
          $error("unexpected byte %02h (transfer_start %0b last %0b)",
                 out_ch.out_byte, out_ch.transfer_start, out_ch.last);
        end else begin
          exp_b = bytes_due.pop_front();
          if (out_ch.out_byte !== exp_b.value) begin
            errors++;
            $error("out_byte: expected %02h, got %02h", exp_b.value, out_ch.out_byte);
          end
          if (out_ch.transfer_start !== exp_b.opens) begin
            errors++;
            $error("transfer_start: expected %0b, got %0b", exp_b.opens,
                   out_ch.transfer_start);
          end
          if (out_ch.last !== exp_b.fin) begin
            errors++;
            $error("last: expected %0b, got %0b", exp_b.fin, out_ch.last);
          end
        end
      end
    end
  end

  // character driver
  always @(negedge clk) begin
    char_item_t nxt;
    if (rst_n && !(in_ch.valid && !in_fired)) begin
      if (in_gap > 0) begin
        in_gap--;
        in_ch.valid <= 1'b0;
      end else if (char_fifo.size() != 0) begin
        nxt = char_fifo.pop_front();
        in_ch.char_code     <= nxt.code;
        in_ch.start_of_text <= nxt.sot;
        in_ch.valid         <= 1'b1;
        in_gap = in_burst ? 0 : $urandom_range(0, 15);
        if ($urandom_range(0, 15) == 0) in_burst = !in_burst;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // byte sink with random stalls
  always @(negedge clk) begin
    if (rst_n) begin
      if (out_fired) begin
        out_stall = out_burst ? 0 : $urandom_range(0, 15);
        if ($urandom_range(0, 31) == 0) out_burst = !out_burst;
      end
      if (out_stall > 0) begin
        out_stall--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  initial begin
    int budget;
    int n;
    int pick;
    in_ch.valid         = 1'b0;
    in_ch.char_code     = '0;
    in_ch.start_of_text = 1'b0;
    out_ch.ready        = 1'b0;
    rst_n     = 1'b0;
    in_fired  = 1'b0;
    out_fired = 1'b0;
    in_gap    = 0;
    out_stall = 0;
    in_burst  = 1'b0;
    out_burst = 1'b0;
    errors = 0;
    cycles = 0;
    glyphs_drawn = 0;
    line_wraps = 0;
    nul_stops = 0;
    screen_full_stops = 0;
    bytes_checked = 0;
    col_pos  = '0;
    page_pos = '0;
    halted   = 1'b0;

    // directed
    add_char("A", 1'b1);
    add_char(FIRST_PRINT, 1'b0);
    add_char(LAST_PRINT, 1'b0);
    add_char(8'h7F, 1'b0);
    add_char(8'hFF, 1'b0);
    add_char(8'h1F, 1'b0);
    add_char(8'h80, 1'b0);
    add_char("0", 1'b0);
    add_char(NUL, 1'b0);
    add_char("B", 1'b0);
    add_char(NUL, 1'b0);
    add_char(NUL, 1'b1);
    add_char("C", 1'b0);
    add_char(8'h55, 1'b1);
    add_char(8'hAA, 1'b1);
    add_char("z", 1'b0);
    add_char(8'h01, 1'b0);
    add_char("|", 1'b0);
    add_char(NUL, 1'b0);

    // random
    fill_screen();
    add_char(any_printable(), 1'b0);
    budget = 0;
    while (budget < 100) begin
      pick = $urandom_range(0, 18);
      if (pick < 16) begin
        n = $urandom_range(1, 30);
        for (int i = 0; i < n; i++)
          add_char(($urandom_range(0, 9) == 0) ? any_skipped() : any_printable(),
                   i == 0 && pick < 14);
        if ($urandom_range(0, 1) == 0) add_char(NUL, 1'b0);
        budget += n;
      end else begin
        add_char(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        budget++;
      end
    end

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (char_fifo.size() != 0 || in_ch.valid || bytes_due.size() != 0)
      @(posedge clk);
    repeat (40) @(posedge clk);

    if (bytes_due.size() != 0) begin
      errors++;
      $error("%0d expected bytes never arrived", bytes_due.size());
    end
    $display("Drew %0d glyphs, checked %0d bytes; %0d line wraps.",
             glyphs_drawn, bytes_checked, line_wraps);
    $display("Text ended %0d times by NUL and %0d times past the last page.",
             nul_stops, screen_full_stops);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
